[rtl/core/gnpa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gnpa_pkg
// Shared constants for the greedy nearest-pair assigner: defaults, field
// widths, op and status codes.
// ----------------------------------------------------------------------------
package gnpa_pkg;

   // default sizes
   localparam int DEF_MAX_REQUESTERS = 32;
   localparam int DEF_MAX_RESOURCES  = 64;
   localparam int DEF_COORD_BITS     = 10;

   // beat field widths
   localparam int OP_W      = 2;
   localparam int POS_W     = 10;
   localparam int REQ_IDX_W = 5;
   localparam int RES_IDX_W = 6;
   localparam int STATUS_W  = 1;

   // bus widths
   localparam int REQ_DATA_W = 24;   // pos_x, pos_y, pad
   localparam int RSP_DATA_W = 16;   // requester_index, resource_index, pad

   // op codes
   localparam logic [OP_W-1:0] OP_LOAD_REQ = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_RES = 2'd1;
   localparam logic [OP_W-1:0] OP_START    = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK  = 1'b0;
   localparam logic [STATUS_W-1:0] STATUS_ERR = 1'b1;

endpackage : gnpa_pkg
`default_nettype wire

[rtl/core/gnpa_nearest.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gnpa_nearest
// Distance stage and running-minimum compare for one matching round.
// Candidates arrive in (requester, resource) order; strict less-than keeps
// the earliest pair on equal distance.
// ----------------------------------------------------------------------------
module gnpa_nearest #(
   parameter int COORD_BITS = 10,
   parameter int REQ_IW     = 5,
   parameter int RES_IW     = 6
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   clr,        // new round: forget the best pair
   input  wire                   cand_vld,   // free resource beat from memory
   input  wire [RES_IW-1:0]      cand_b,
   input  wire [COORD_BITS-1:0]  cand_x,
   input  wire [COORD_BITS-1:0]  cand_y,
   input  wire [REQ_IW-1:0]      cur_w,
   input  wire [COORD_BITS-1:0]  cur_x,
   input  wire [COORD_BITS-1:0]  cur_y,
   output logic [REQ_IW-1:0]     best_w,
   output logic [RES_IW-1:0]     best_b,
   output logic [COORD_BITS-1:0] best_wx,
   output logic [COORD_BITS-1:0] best_wy,
   output logic [COORD_BITS-1:0] best_rx,
   output logic [COORD_BITS-1:0] best_ry
);

   localparam int DIST_W = COORD_BITS + 1;

   logic [COORD_BITS-1:0] dx, dy;
   logic [DIST_W-1:0]     pair_d;

   logic                  s2_vld_ff;
   logic [DIST_W-1:0]     s2_d_ff;
   logic [RES_IW-1:0]     s2_b_ff;
   logic [COORD_BITS-1:0] s2_rx_ff, s2_ry_ff;

   logic                  found_ff;
   logic [DIST_W-1:0]     best_d_ff;
   logic [REQ_IW-1:0]     best_w_ff;
   logic [RES_IW-1:0]     best_b_ff;
   logic [COORD_BITS-1:0] best_wx_ff, best_wy_ff, best_rx_ff, best_ry_ff;
   logic                  take;

   always_comb begin
      dx     = (cur_x > cand_x) ? (cur_x - cand_x) : (cand_x - cur_x);
      dy     = (cur_y > cand_y) ? (cur_y - cand_y) : (cand_y - cur_y);
      pair_d = {1'b0, dx} + {1'b0, dy};
   end

   // stage 2: registered distance
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= cand_vld;
      end
      s2_d_ff  <= pair_d;
      s2_b_ff  <= cand_b;
      s2_rx_ff <= cand_x;
      s2_ry_ff <= cand_y;
   end

   assign take = s2_vld_ff && (!found_ff || (s2_d_ff < best_d_ff));

   // stage 3: running minimum; requester stays put until the scan drains
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (clr) begin
         found_ff <= 1'b0;
      end else if (take) begin
         found_ff <= 1'b1;
      end
      if (take) begin
         best_d_ff  <= s2_d_ff;
         best_w_ff  <= cur_w;
         best_b_ff  <= s2_b_ff;
         best_wx_ff <= cur_x;
         best_wy_ff <= cur_y;
         best_rx_ff <= s2_rx_ff;
         best_ry_ff <= s2_ry_ff;
      end
   end

   assign best_w  = best_w_ff;
   assign best_b  = best_b_ff;
   assign best_wx = best_wx_ff;
   assign best_wy = best_wy_ff;
   assign best_rx = best_rx_ff;
   assign best_ry = best_ry_ff;

endmodule : gnpa_nearest
`default_nettype wire

[rtl/core/greedy_nearest_pair_assigner_unit.sv]
`default_nettype none
// Run: a start runs R rounds (R = requesters). A round fetches each requester in
//   turn, skips matched ones, scans all S resources (S = resources) for each
//   free one and then writes back the chosen pair; results then leave one per
//   requester in index order. A start with bad counts returns one error result.
// Throughput: loads stream 1 per cycle while idle; start is bound by the resource read port.
// Reset: synchronous, active high; clears counts, FSM and valid flags only.
// ----------------------------------------------------------------------------
// greedy_nearest_pair_assigner_unit
// Greedy Manhattan bipartite assignment over requester and resource points
// held in two synchronous memories with one write and one read port each.
// ----------------------------------------------------------------------------
module greedy_nearest_pair_assigner_unit
   #(
   parameter int MAX_REQUESTERS = gnpa_pkg::DEF_MAX_REQUESTERS,
   parameter int MAX_RESOURCES  = gnpa_pkg::DEF_MAX_RESOURCES,
   parameter int COORD_BITS     = gnpa_pkg::DEF_COORD_BITS
) (
   input  wire                                  clock,
   input  wire                                  reset,
   // request stream
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  wire [gnpa_pkg::REQ_DATA_W-1:0]       req_tdata,  // pos_x[9:0], pos_y[19:10], pad
   input  wire [gnpa_pkg::OP_W-1:0]             req_tuser,  // op[1:0]
   // response stream
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [gnpa_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // requester_index[4:0],
                                                            // resource_index[10:5], pad
   output logic [gnpa_pkg::STATUS_W-1:0]        rsp_tuser,  // status[0]
   output logic                                 rsp_tlast   // last result of the run
);

   import gnpa_pkg::*;

   // index and count widths
   localparam int REQ_IW = (MAX_REQUESTERS > 1) ? $clog2(MAX_REQUESTERS) : 1;
   localparam int RES_IW = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
   localparam int REQ_CW = $clog2(MAX_REQUESTERS + 1);
   localparam int RES_CW = $clog2(MAX_RESOURCES + 1);

   // requester entry: {done, assigned, y, x}
   localparam int REQ_EW   = 1 + RES_IW + 2 * COORD_BITS;
   localparam int REQ_DONE = REQ_EW - 1;
   // resource entry: {taken, y, x}
   localparam int RES_EW    = 1 + 2 * COORD_BITS;
   localparam int RES_TAKEN = RES_EW - 1;

   typedef enum logic [8:0] {
      ST_IDLE      = 9'b0_0000_0001,
      ST_REQ_RD    = 9'b0_0000_0010,  // fetch requester w
      ST_REQ_CHK   = 9'b0_0000_0100,  // skip if already matched
      ST_SCAN      = 9'b0_0000_1000,  // one resource read per cycle
      ST_DRAIN     = 9'b0_0001_0000,  // let the distance pipe empty
      ST_ROUND_END = 9'b0_0010_0000,  // write back the chosen pair
      ST_OUT_RD    = 9'b0_0100_0000,
      ST_OUT_PUT   = 9'b0_1000_0000,
      ST_ERR_PUT   = 9'b1_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // memories
   logic [REQ_EW-1:0] req_mem [MAX_REQUESTERS];
   logic [RES_EW-1:0] res_mem [MAX_RESOURCES];
   logic [REQ_EW-1:0] req_rd_ff;
   logic [RES_EW-1:0] res_rd_ff;

   logic              req_we, res_we;
   logic [REQ_IW-1:0] req_wa;
   logic [RES_IW-1:0] res_wa;
   logic [REQ_EW-1:0] req_wd;
   logic [RES_EW-1:0] res_wd;

   // control registers
   logic [REQ_CW-1:0] req_cnt_ff, req_cnt_in;
   logic [RES_CW-1:0] res_cnt_ff, res_cnt_in;
   logic [REQ_IW-1:0] w_ff, w_in;
   logic [REQ_IW-1:0] round_ff, round_in;
   logic [RES_IW-1:0] b_ff, b_in;
   logic              drain_ff, drain_in;
   logic              s1_vld_ff;
   logic [RES_IW-1:0] s1_b_ff;
   logic [COORD_BITS-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;

   // output register
   logic                  rsp_vld_ff, rsp_vld_in;
   logic [REQ_IDX_W-1:0]  rsp_req_ff, rsp_req_in;
   logic [RES_IDX_W-1:0]  rsp_res_ff, rsp_res_in;
   logic [STATUS_W-1:0]   rsp_st_ff, rsp_st_in;
   logic                  rsp_last_ff, rsp_last_in;

   // decoded beat
   logic [POS_W-1:0]      in_pos_x, in_pos_y;
   logic [COORD_BITS-1:0] in_x, in_y;
   logic                  in_take;

   logic                  out_free;
   logic [REQ_IW-1:0]     req_last;
   logic [RES_IW-1:0]     res_last;
   logic                  w_at_last, bad_counts, round_clr;

   logic [REQ_IW-1:0]     best_w;
   logic [RES_IW-1:0]     best_b;
   logic [COORD_BITS-1:0] best_wx, best_wy, best_rx, best_ry;

   assign in_pos_x = req_tdata[POS_W-1:0];
   assign in_pos_y = req_tdata[2*POS_W-1:POS_W];
   assign in_x     = COORD_BITS'(in_pos_x);
   assign in_y     = COORD_BITS'(in_pos_y);

   assign req_tready = (state_ff == ST_IDLE);
   assign in_take    = req_tvalid && req_tready;
   assign out_free   = !rsp_vld_ff || rsp_tready;

   assign req_last   = REQ_IW'(req_cnt_ff - 1'b1);
   assign res_last   = RES_IW'(res_cnt_ff - 1'b1);
   assign w_at_last  = (w_ff == req_last);
   assign bad_counts = (req_cnt_ff == '0) || (int'(res_cnt_ff) < int'(req_cnt_ff));

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in    = state_ff;
      req_cnt_in  = req_cnt_ff;
      res_cnt_in  = res_cnt_ff;
      w_in        = w_ff;
      round_in    = round_ff;
      b_in        = b_ff;
      drain_in    = drain_ff;
      cur_x_in    = cur_x_ff;
      cur_y_in    = cur_y_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_req_in  = rsp_req_ff;
      rsp_res_in  = rsp_res_ff;
      rsp_st_in   = rsp_st_ff;
      rsp_last_in = rsp_last_ff;
      round_clr   = 1'b0;

      req_we = 1'b0;
      req_wa = req_cnt_ff[REQ_IW-1:0];
      req_wd = {1'b0, {RES_IW{1'b0}}, in_y, in_x};
      res_we = 1'b0;
      res_wa = res_cnt_ff[RES_IW-1:0];
      res_wd = {1'b0, in_y, in_x};

      unique case (state_ff)
         ST_IDLE: begin
            if (in_take) begin
               case (req_tuser)
                  OP_LOAD_REQ: begin
                     if (int'(req_cnt_ff) < MAX_REQUESTERS) begin
                        req_we     = 1'b1;
                        req_cnt_in = req_cnt_ff + 1'b1;
                     end
                  end
                  OP_LOAD_RES: begin
                     if (int'(res_cnt_ff) < MAX_RESOURCES) begin
                        res_we     = 1'b1;
                        res_cnt_in = res_cnt_ff + 1'b1;
                     end
                  end
                  OP_START: begin
                     if (bad_counts) begin
                        state_in = ST_ERR_PUT;
                     end else begin
                        w_in      = '0;
                        round_in  = '0;
                        round_clr = 1'b1;
                        state_in  = ST_REQ_RD;
                     end
                  end
                  default: ;  // unused op: no effect
               endcase
            end
         end
         ST_REQ_RD: begin
            state_in = ST_REQ_CHK;
         end
         ST_REQ_CHK: begin
            if (req_rd_ff[REQ_DONE]) begin
               if (w_at_last) begin
                  state_in = ST_ROUND_END;
               end else begin
                  w_in     = w_ff + 1'b1;
                  state_in = ST_REQ_RD;
               end
            end else begin
               cur_x_in = req_rd_ff[COORD_BITS-1:0];
               cur_y_in = req_rd_ff[2*COORD_BITS-1:COORD_BITS];
               b_in     = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (b_ff == res_last) begin
               drain_in = 1'b0;
               state_in = ST_DRAIN;
            end else begin
               b_in = b_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            // wait out the memory read stage and the distance stage
            if (drain_ff) begin
               if (w_at_last) begin
                  state_in = ST_ROUND_END;
               end else begin
                  w_in     = w_ff + 1'b1;
                  state_in = ST_REQ_RD;
               end
            end else begin
               drain_in = 1'b1;
            end
         end
         ST_ROUND_END: begin
            req_we = 1'b1;
            req_wa = best_w;
            req_wd = {1'b1, best_b, best_wy, best_wx};
            res_we = 1'b1;
            res_wa = best_b;
            res_wd = {1'b1, best_ry, best_rx};
            w_in   = '0;
            if (round_ff == req_last) begin
               state_in = ST_OUT_RD;
            end else begin
               round_in  = round_ff + 1'b1;
               round_clr = 1'b1;
               state_in  = ST_REQ_RD;
            end
         end
         ST_OUT_RD: begin
            state_in = ST_OUT_PUT;
         end
         ST_OUT_PUT: begin
            if (out_free) begin
               rsp_vld_in  = 1'b1;
               rsp_req_in  = REQ_IDX_W'(w_ff);
               rsp_res_in  = RES_IDX_W'(req_rd_ff[REQ_DONE-1:2*COORD_BITS]);
               rsp_st_in   = STATUS_OK;
               rsp_last_in = w_at_last;
               if (w_at_last) begin
                  req_cnt_in = '0;
                  res_cnt_in = '0;
                  state_in   = ST_IDLE;
               end else begin
                  w_in     = w_ff + 1'b1;
                  state_in = ST_OUT_RD;
               end
            end
         end
         ST_ERR_PUT: begin
            if (out_free) begin
               rsp_vld_in  = 1'b1;
               rsp_req_in  = '0;
               rsp_res_in  = '0;
               rsp_st_in   = STATUS_ERR;
               rsp_last_in = 1'b1;
               req_cnt_in  = '0;
               res_cnt_in  = '0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         req_cnt_ff <= '0;
         res_cnt_ff <= '0;
         rsp_vld_ff <= 1'b0;
         s1_vld_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         req_cnt_ff <= req_cnt_in;
         res_cnt_ff <= res_cnt_in;
         rsp_vld_ff <= rsp_vld_in;
         s1_vld_ff  <= (state_ff == ST_SCAN);
      end
      w_ff        <= w_in;
      round_ff    <= round_in;
      b_ff        <= b_in;
      drain_ff    <= drain_in;
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      s1_b_ff     <= b_ff;
      rsp_req_ff  <= rsp_req_in;
      rsp_res_ff  <= rsp_res_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_last_ff <= rsp_last_in;
   end

   // ---------------------------------------------------------------------
   // Point memories: one write and one registered read per cycle each.
   // Taken and done marks are cleared when an entry is loaded, so entries
   // below the counts never carry marks from an earlier job.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_we) begin
         req_mem[req_wa] <= req_wd;
      end
      req_rd_ff <= req_mem[w_ff];
   end

   always_ff @(posedge clock) begin
      if (res_we) begin
         res_mem[res_wa] <= res_wd;
      end
      res_rd_ff <= res_mem[b_ff];
   end

   // ---------------------------------------------------------------------
   // Distance and best-pair tracking
   // ---------------------------------------------------------------------
   gnpa_nearest #(
      .COORD_BITS (COORD_BITS),
      .REQ_IW     (REQ_IW),
      .RES_IW     (RES_IW)
   ) u_nearest (
      .clock    (clock),
      .reset    (reset),
      .clr      (round_clr),
      .cand_vld (s1_vld_ff && !res_rd_ff[RES_TAKEN]),
      .cand_b   (s1_b_ff),
      .cand_x   (res_rd_ff[COORD_BITS-1:0]),
      .cand_y   (res_rd_ff[2*COORD_BITS-1:COORD_BITS]),
      .cur_w    (w_ff),
      .cur_x    (cur_x_ff),
      .cur_y    (cur_y_ff),
      .best_w   (best_w),
      .best_b   (best_b),
      .best_wx  (best_wx),
      .best_wy  (best_wy),
      .best_rx  (best_rx),
      .best_ry  (best_ry)
   );

   // response beat
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - REQ_IDX_W - RES_IDX_W){1'b0}}, rsp_res_ff, rsp_req_ff};
   assign rsp_tuser  = rsp_st_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule : greedy_nearest_pair_assigner_unit
`default_nettype wire
